>>> rtl/m3inv_pkg.sv
package m3inv_pkg;

  localparam int ELEM_WIDTH    = 32;
  localparam int DEF_FRAC_BITS = 16;
  localparam int THR_WIDTH     = 31;
  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_00;
    logic signed [ELEM_WIDTH-1:0] elem_01;
    logic signed [ELEM_WIDTH-1:0] elem_02;
    logic signed [ELEM_WIDTH-1:0] elem_10;
    logic signed [ELEM_WIDTH-1:0] elem_11;
    logic signed [ELEM_WIDTH-1:0] elem_12;
    logic signed [ELEM_WIDTH-1:0] elem_20;
    logic signed [ELEM_WIDTH-1:0] elem_21;
    logic signed [ELEM_WIDTH-1:0] elem_22;
  } m3inv_in_t;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] inv_00;
    logic signed [ELEM_WIDTH-1:0] inv_01;
    logic signed [ELEM_WIDTH-1:0] inv_02;
    logic signed [ELEM_WIDTH-1:0] inv_10;
    logic signed [ELEM_WIDTH-1:0] inv_11;
    logic signed [ELEM_WIDTH-1:0] inv_12;
    logic signed [ELEM_WIDTH-1:0] inv_20;
    logic signed [ELEM_WIDTH-1:0] inv_21;
    logic signed [ELEM_WIDTH-1:0] inv_22;
    logic                         singular;
    logic                         overflow;
  } m3inv_out_t;

endpackage

>>> rtl/matrix3x3_inverse_top.sv
// Channel | Direction | Handshake                | Beat
// in      | input     | in_valid_i / in_ready_o  | m3inv_in_t, one 3x3 matrix
// out     | output    | out_valid_o / out_ready_i| m3inv_out_t, inverse and flags
// cfg     | input     | cfg_valid_i / cfg_ready_o| singular threshold, 31 bits
//
// One matrix enters per cycle while in_ready_o is high.
// Most of the pipeline is the restoring divider: nine lanes, one quotient bit per stage.
// Ahead of it come input, product, cofactor, first-row term, determinant, magnitude and numerator stages.
// Reset clears only valid bits and sets the threshold to one.
// An output register plus a skid register decouple the sides; while the skid
// register is full the whole pipeline holds and in_ready_o is low.
module matrix3x3_inverse_top
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  m3inv_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output m3inv_out_t           out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [THR_WIDTH-1:0] cfg_data_i
);

  localparam int W    = ELEM_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * W;
  localparam int AW   = 2 * W + 1;
  localparam int LPW  = 2 * W + 1;
  localparam int DW   = 3 * W + 3;
  localparam int NW0  = (AW + 2 * F + 1 > DW) ? AW + 2 * F + 1 : DW;
  localparam int NW   = NW0 + 1;
  localparam int CW   = (NW > DW + W + 2) ? NW : DW + W + 2;
  localparam int CMPW = (DW > THR_WIDTH + 2 * F) ? DW : THR_WIDTH + 2 * F;
  localparam int QW   = W + 2;
  localparam int NDIV = W + 2;

  // Cofactor i = e[CA]*e[CB] - e[CC]*e[CD].
  localparam int CA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic                 en;
  logic [THR_WIDTH-1:0] thr_q;

  logic signed [W-1:0]   e_d   [9];
  logic signed [W-1:0]   e1_q  [9];
  logic signed [PW-1:0]  p_d   [18];
  logic signed [PW-1:0]  p2_q  [18];
  logic signed [W-1:0]   er2_q [3];
  logic signed [AW-1:0]  adj_d [9];
  logic signed [AW-1:0]  adj3_q [9];
  logic signed [W-1:0]   er3_q [3];
  logic signed [LPW-1:0] pl_d  [3];
  logic signed [LPW-1:0] ph_d  [3];
  logic signed [LPW-1:0] pl4_q [3];
  logic signed [LPW-1:0] ph4_q [3];
  logic signed [AW-1:0]  adj4_q [9];
  logic signed [DW-1:0]  term_d [3];
  logic signed [DW-1:0]  term5_q [3];
  logic signed [AW-1:0]  adj5_q [9];
  logic signed [DW-1:0]  det6_q;
  logic signed [AW-1:0]  adj6_q [9];
  logic [DW-1:0]         dabs_d;
  logic [DW-1:0]         dabs7_q;
  logic [AW-1:0]         aabs_d [9];
  logic [AW-1:0]         aabs7_q [9];
  logic [8:0]            neg_d, neg7_q;
  logic                  v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  logic [CW-1:0]   dr_q   [NDIV+1][9];
  logic [QW-1:0]   dq_q   [NDIV+1][9];
  logic [DW:0]     dd2_q  [NDIV+1];
  logic [8:0]      dneg_q [NDIV+1];
  logic            dsing_q [NDIV+1];
  logic            dv_q   [NDIV+1];

  m3inv_out_t res_d, out_q, skid_q;
  logic       out_vq, skid_vq;

  assign en          = !skid_vq;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign e_d[0] = in_data_i.elem_00;
  assign e_d[1] = in_data_i.elem_01;
  assign e_d[2] = in_data_i.elem_02;
  assign e_d[3] = in_data_i.elem_10;
  assign e_d[4] = in_data_i.elem_11;
  assign e_d[5] = in_data_i.elem_12;
  assign e_d[6] = in_data_i.elem_20;
  assign e_d[7] = in_data_i.elem_21;
  assign e_d[8] = in_data_i.elem_22;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p_d[2*i]   = PW'(e1_q[CA[i]]) * PW'(e1_q[CB[i]]);
      p_d[2*i+1] = PW'(e1_q[CC[i]]) * PW'(e1_q[CD[i]]);
      adj_d[i]   = AW'(p2_q[2*i]) - AW'(p2_q[2*i+1]);
    end
    // Each first-row term e*adj is split on the low W bits of the cofactor.
    for (int t = 0; t < 3; t++) begin
      pl_d[t]   = LPW'(er3_q[t]) * LPW'($signed({1'b0, adj3_q[3*t][W-1:0]}));
      ph_d[t]   = LPW'(er3_q[t]) * LPW'($signed(adj3_q[3*t][AW-1:W]));
      term_d[t] = (DW'(ph4_q[t]) <<< W) + DW'(pl4_q[t]);
    end
    dabs_d = det6_q[DW-1] ? DW'(-det6_q) : DW'(det6_q);
    for (int i = 0; i < 9; i++) begin
      aabs_d[i] = adj6_q[i][AW-1] ? AW'(-adj6_q[i]) : AW'(adj6_q[i]);
      neg_d[i]  = adj6_q[i][AW-1] ^ det6_q[DW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q  <= e_d;
      p2_q  <= p_d;
      for (int t = 0; t < 3; t++) begin
        er2_q[t] <= e1_q[t];
        er3_q[t] <= er2_q[t];
      end
      adj3_q  <= adj_d;
      pl4_q   <= pl_d;
      ph4_q   <= ph_d;
      adj4_q  <= adj3_q;
      term5_q <= term_d;
      adj5_q  <= adj4_q;
      det6_q  <= term5_q[0] + term5_q[1] + term5_q[2];
      adj6_q  <= adj5_q;
      dabs7_q <= dabs_d;
      aabs7_q <= aabs_d;
      neg7_q  <= neg_d;
    end
  end

  // Numerator is 2*|adj|*2^(2F) + |det| over 2*|det|: rounds half away from zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        dr_q[0][i] <= (CW'(aabs7_q[i]) << (2 * F + 1)) + CW'(dabs7_q);
        dq_q[0][i] <= '0;
      end
      dd2_q[0]   <= {dabs7_q, 1'b0};
      dneg_q[0]  <= neg7_q;
      dsing_q[0] <= CMPW'(dabs7_q) <= (CMPW'(thr_q) << (2 * F));
    end
  end

  // Stage j decides quotient bit W+1-j; the top bit marks a quotient beyond range.
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int K = W + 1 - j;
    logic [CW-1:0] dsh;
    logic [CW:0]   diff [9];

    assign dsh = CW'(dd2_q[j]) << K;

    always_comb begin
      for (int i = 0; i < 9; i++) begin
        diff[i] = {1'b0, dr_q[j][i]} - {1'b0, dsh};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 9; i++) begin
          dr_q[j+1][i] <= diff[i][CW] ? dr_q[j][i] : diff[i][CW-1:0];
          dq_q[j+1][i] <= {dq_q[j][i][QW-2:0], !diff[i][CW]};
        end
        dd2_q[j+1]   <= dd2_q[j];
        dneg_q[j+1]  <= dneg_q[j];
        dsing_q[j+1] <= dsing_q[j];
      end
    end
  end

  always_comb begin
    logic [W:0]   lim;
    logic [W:0]   mag;
    logic [W:0]   sval;
    logic         sat;
    logic [W-1:0] r [9];
    logic         ovf;
    ovf = 1'b0;
    for (int i = 0; i < 9; i++) begin
      lim  = dneg_q[NDIV][i] ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - 1'b1);
      sat  = dq_q[NDIV][i][QW-1] || (dq_q[NDIV][i][W:0] > lim);
      mag  = sat ? lim : dq_q[NDIV][i][W:0];
      sval = dneg_q[NDIV][i] ? (W+1)'(-mag) : mag;
      r[i] = dsing_q[NDIV] ? '0 : sval[W-1:0];
      ovf  = ovf | sat;
    end
    res_d.inv_00   = r[0];
    res_d.inv_01   = r[1];
    res_d.inv_02   = r[2];
    res_d.inv_10   = r[3];
    res_d.inv_11   = r[4];
    res_d.inv_12   = r[5];
    res_d.inv_20   = r[6];
    res_d.inv_21   = r[7];
    res_d.inv_22   = r[8];
    res_d.singular = dsing_q[NDIV];
    res_d.overflow = ovf & !dsing_q[NDIV];
  end

  // The skid register catches the beat that leaves the pipeline while out is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (out_ready_i || !out_vq) begin
      if (skid_vq) begin
        out_vq  <= 1'b1;
        skid_vq <= 1'b0;
      end else begin
        out_vq <= dv_q[NDIV];
      end
    end else if (en && dv_q[NDIV]) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_vq) begin
      out_q <= skid_vq ? skid_q : res_d;
    end else if (en && dv_q[NDIV]) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_vq;
  assign out_data_o  = out_q;

  a_sing_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |-> !out_data_o.overflow)
    else $error("overflow raised on a singular result");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |-> out_data_o.inv_00 == '0 && out_data_o.inv_11 == '0
      && out_data_o.inv_22 == '0)
    else $error("singular result carries nonzero elements");

  a_skid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("skid register full with output register empty");

endmodule
